// ===== rtl/run_moment_line_classifier_macros.svh =====
// Assertion macros shared by the run moment line classifier RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RUN_MOMENT_LINE_CLASSIFIER_MACROS_SVH
`define RUN_MOMENT_LINE_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RMLC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmlc check failed");

// Next-cycle implication, disabled while reset is asserted
`define RMLC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmlc check failed");

`endif

// ===== rtl/rmlc_pkg.sv =====
// Shared widths, codes, types and saturation helpers of the run moment line classifier.
// No dependencies; imported by rmlc_wide_unit and run_moment_line_classifier.
package rmlc_pkg;

    localparam int CB      = 13;
    localparam int CNT_W   = 2 * CB + 1;
    localparam int X2_W    = 3 * CB + 2;
    localparam int Y_W     = 3 * CB + 1;
    localparam int YY_W    = 4 * CB + 1;
    localparam int XY2_W   = 4 * CB + 2;
    localparam int XX6_W   = 4 * CB + 3;
    localparam int CTR_W   = CB + 8;
    localparam int AVW_W   = CB + 9;
    localparam int LEN_W   = CB + 1;
    localparam int MS_W    = 2 * CB + 3;
    localparam int MOM_W   = 48;
    localparam int SLP_W   = 16;
    localparam int INCL_W  = 15;
    localparam int RAT_W   = 16;
    localparam int MDIV_W  = 32;
    localparam int CFG_W   = 32;
    localparam int WIDE_W  = 128;
    localparam int IT_W    = $clog2(WIDE_W);

    localparam logic [CB-1:0] LEFT_RST = '0;

    localparam logic signed [WIDE_W-1:0] SLP_MAX =
        {{(WIDE_W-SLP_W+1){1'b0}}, {(SLP_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] SLP_MIN =
        {{(WIDE_W-SLP_W+1){1'b1}}, {(SLP_W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] MOM_MAX =
        {{(WIDE_W-MOM_W+1){1'b0}}, {(MOM_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] MOM_MIN =
        {{(WIDE_W-MOM_W+1){1'b1}}, {(MOM_W-1){1'b0}}};
    localparam logic [WIDE_W-1:0] CTR_MAX = {{(WIDE_W-CTR_W){1'b0}}, {CTR_W{1'b1}}};
    localparam logic [WIDE_W-1:0] AVW_MAX = {{(WIDE_W-AVW_W){1'b0}}, {AVW_W{1'b1}}};

    // Axis moment of one unit, Q44.4
    localparam logic signed [MOM_W-1:0] MOM_ONE = MOM_W'(16);

    typedef enum logic [1:0] {
        CFG_MIN_DIV    = 2'd0,
        CFG_DEG_SLOPE  = 2'd1,
        CFG_MAX_INCL   = 2'd2,
        CFG_MIN_RATIO  = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        WU_MUL = 1'b0,
        WU_DIV = 1'b1
    } t_wu_op;

    typedef struct packed {
        logic   start;
        t_wu_op op;
    } t_wu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_wu_st;

    function automatic logic signed [SLP_W-1:0] f_sat_slp(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = (v > SLP_MAX) ? SLP_MAX : ((v < SLP_MIN) ? SLP_MIN : v);
        return c[SLP_W-1:0];
    endfunction

    function automatic logic signed [MOM_W-1:0] f_sat_mom(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] c;
        c = (v > MOM_MAX) ? MOM_MAX : ((v < MOM_MIN) ? MOM_MIN : v);
        return c[MOM_W-1:0];
    endfunction

    function automatic logic [CTR_W-1:0] f_sat_ctr(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] c;
        c = (v > CTR_MAX) ? CTR_MAX : v;
        return c[CTR_W-1:0];
    endfunction

    function automatic logic [AVW_W-1:0] f_sat_avw(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] c;
        c = (v > AVW_MAX) ? AVW_MAX : v;
        return c[AVW_W-1:0];
    endfunction

endpackage

// ===== rtl/run_moment_line_classifier.sv =====
// Run moment line classifier: each run is accepted, then takes 8 steps on a shared 29x29 multiplier.
// A run marked last adds the end-of-blob pass on the bit-serial wide unit (one multiplier
// bit or one quotient bit per cycle); the slope and moment steps are skipped when the moment
// difference is near zero, and there is no pass at all when the pixel count wraps to zero.
// One run in flight; the next is taken while a finished result waits at the output.
// Synchronous active-low reset loads register defaults and clears sums; no clearing pass.
`include "run_moment_line_classifier_macros.svh"
module run_moment_line_classifier import rmlc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [CB-1:0]           i_x_start,
    input  logic [CB-1:0]           i_x_end,
    input  logic [CB-1:0]           i_row,
    input  logic                    i_last_run,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_is_line,
    output logic [CTR_W-1:0]        o_center_x,
    output logic [CTR_W-1:0]        o_center_y,
    output logic signed [SLP_W-1:0] o_slope,
    output logic signed [MOM_W-1:0] o_across_moment,
    output logic signed [MOM_W-1:0] o_along_moment,
    output logic [AVW_W-1:0]        o_average_width,
    output logic [CB-1:0]           o_left_edge,
    output logic [CB-1:0]           o_right_edge,
    output logic [CNT_W-1:0]        o_pixel_count,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_cfg_idx                i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RUN    = 5'b00010,
        S_LAUNCH = 5'b00100,
        S_WAIT   = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    typedef enum logic [3:0] {
        ST_A0, ST_A1, ST_B0, ST_B1, ST_C0, ST_C1, ST_LIM, ST_CX,
        ST_CY, ST_AVW, ST_SLOPE, ST_DS2, ST_BS, ST_ACROSS, ST_ALONG, ST_RATIO
    } t_step;

    t_state r_state;
    t_step  r_step;
    logic [2:0] r_rstep;

    // configuration
    logic [MDIV_W-1:0]       r_min_div;
    logic signed [SLP_W-1:0] r_deg_slope;
    logic [INCL_W-1:0]       r_max_incl;
    logic [RAT_W-1:0]        r_min_ratio;

    // current run
    logic [CB-1:0] r_xs, r_xe, r_y;
    logic [CB:0]   r_d, r_sp;
    logic          r_last;

    // blob sums
    logic [CNT_W-1:0] r_cnt;
    logic [X2_W-1:0]  r_x2;
    logic [Y_W-1:0]   r_ysum;
    logic [YY_W-1:0]  r_yy;
    logic [XY2_W-1:0] r_xy2;
    logic [XX6_W-1:0] r_xx6;
    logic [CB-1:0]    r_min_left, r_max_right;
    logic             r_have_run;

    // run multiplier
    logic [MS_W-1:0]   w_ma, w_mb;
    logic [2*MS_W-1:0] r_prod;
    logic [MS_W-1:0]   r_sq, r_p1, r_p2, r_q;
    logic [LEN_W-1:0]  r_len;

    // end-of-blob values
    logic signed [WIDE_W-1:0] r_t0, r_a12, r_b12, r_c12, r_dd, r_dd_abs;
    logic signed [WIDE_W-1:0] r_lim, r_ds2, r_bs, r_rprod;
    logic                     r_degen;
    logic [CTR_W-1:0]         r_cx, r_cy;
    logic [AVW_W-1:0]         r_avw;
    logic signed [SLP_W-1:0]  r_slope;
    logic signed [MOM_W-1:0]  r_across, r_along;

    // output beat
    logic                    r_out_valid;
    logic                    r_o_line;
    logic [CTR_W-1:0]        r_o_cx, r_o_cy;
    logic signed [SLP_W-1:0] r_o_slope;
    logic signed [MOM_W-1:0] r_o_across, r_o_along;
    logic [AVW_W-1:0]        r_o_avw;
    logic [CB-1:0]           r_o_left, r_o_right;
    logic [CNT_W-1:0]        r_o_cnt;

    // wide unit hookup
    t_wu_ctl                  w_uctl;
    t_wu_st                   w_ust;
    t_wu_op                   w_uop;
    logic signed [WIDE_W-1:0] w_ua, w_ub, w_ures;

    logic          w_in_acc, w_out_free;
    logic [CB-1:0] w_lo, w_hi;
    logic [CB:0]   w_d, w_sp;
    logic [SLP_W-1:0] w_sm;
    logic [WIDE_W-1:0] w_cnt, w_x2, w_ysum;
    logic signed [WIDE_W-1:0] w_along_w;
    logic w_big_n, w_steep, w_long, w_ratio_bad, w_fat, w_thin, w_line;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Order the run ends
    assign w_lo = (i_x_end < i_x_start) ? i_x_end : i_x_start;
    assign w_hi = (i_x_end < i_x_start) ? i_x_start : i_x_end;
    assign w_d  = {1'b0, w_hi} - {1'b0, w_lo} + (CB+1)'(1);
    assign w_sp = {1'b0, w_hi} + {1'b0, w_lo};

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_div   <= MDIV_W'(16);
            r_deg_slope <= '0;
            r_max_incl  <= INCL_W'(1638);
            r_min_ratio <= RAT_W'(2560);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MIN_DIV:   r_min_div   <= i_cfg_data[MDIV_W-1:0];
                CFG_DEG_SLOPE: r_deg_slope <= i_cfg_data[SLP_W-1:0];
                CFG_MAX_INCL:  r_max_incl  <= i_cfg_data[INCL_W-1:0];
                CFG_MIN_RATIO: r_min_ratio <= i_cfg_data[RAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Run multiplier operands: sp^2, d*sp, d*y, xs*xe, (d*sp)*y, (d*y)*y, d*q; else len^2
    always_comb begin
        w_ma = MS_W'(r_len);
        w_mb = MS_W'(r_len);
        if (r_state == S_RUN) begin
            case (r_rstep)
                3'd0: begin w_ma = MS_W'(r_sp); w_mb = MS_W'(r_sp); end
                3'd1: begin w_ma = MS_W'(r_d);  w_mb = MS_W'(r_sp); end
                3'd2: begin w_ma = MS_W'(r_d);  w_mb = MS_W'(r_y);  end
                3'd3: begin w_ma = MS_W'(r_xs); w_mb = MS_W'(r_xe); end
                3'd4: begin w_ma = r_p1;        w_mb = MS_W'(r_y);  end
                3'd5: begin w_ma = r_p2;        w_mb = MS_W'(r_y);  end
                3'd6: begin w_ma = MS_W'(r_d);  w_mb = r_q;         end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= (2*MS_W)'(w_ma) * (2*MS_W)'(w_mb);
    end

    // Wide unit operands per end-of-blob step
    assign w_cnt  = WIDE_W'(r_cnt);
    assign w_x2   = WIDE_W'(r_x2);
    assign w_ysum = WIDE_W'(r_ysum);
    assign w_sm   = r_slope[SLP_W-1] ? SLP_W'(-r_slope) : SLP_W'(r_slope);

    always_comb begin
        w_uop = WU_MUL;
        w_ua  = '0;
        w_ub  = '0;
        unique case (r_step)
            ST_A0:  begin w_ua = w_cnt * 12;  w_ub = WIDE_W'(r_yy);  end
            ST_A1:  begin w_ua = w_ysum * 12; w_ub = w_ysum;         end
            ST_B0:  begin w_ua = w_cnt * 6;   w_ub = WIDE_W'(r_xy2); end
            ST_B1:  begin w_ua = w_x2 * 6;    w_ub = w_ysum;         end
            ST_C0:  begin w_ua = w_cnt * 2;   w_ub = WIDE_W'(r_xx6); end
            ST_C1:  begin w_ua = w_x2 * 3;    w_ub = w_x2;           end
            ST_LIM: begin w_ua = WIDE_W'(r_min_div); w_ub = w_cnt * 12; end
            ST_CX:  begin w_uop = WU_DIV; w_ua = w_x2 << 7;   w_ub = w_cnt; end
            ST_CY:  begin w_uop = WU_DIV; w_ua = w_ysum << 8; w_ub = w_cnt; end
            ST_AVW: begin w_uop = WU_DIV; w_ua = w_cnt << 8;  w_ub = WIDE_W'(r_len); end
            ST_SLOPE: begin w_uop = WU_DIV; w_ua = r_b12 <<< 14; w_ub = r_dd; end
            ST_DS2: begin
                w_ua = r_dd;
                w_ub = WIDE_W'((2*SLP_W)'(w_sm) * (2*SLP_W)'(w_sm));
            end
            ST_BS:  begin w_ua = r_b12; w_ub = WIDE_W'({w_sm, 15'd0}); end
            ST_ACROSS: begin
                w_uop = WU_DIV;
                w_ua  = (r_a12 <<< 28) + r_ds2 - r_bs;
                w_ub  = (w_cnt * 12) << 24;
            end
            ST_ALONG: begin
                w_uop = WU_DIV;
                w_ua  = (r_c12 <<< 28) - r_ds2 + r_bs;
                w_ub  = (w_cnt * 12) << 24;
            end
            ST_RATIO: begin w_ua = WIDE_W'(r_across); w_ub = WIDE_W'(r_min_ratio); end
            default: ;
        endcase
    end

    assign w_uctl.start = (r_state == S_LAUNCH);
    assign w_uctl.op    = w_uop;

    rmlc_wide_unit u_wide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_uctl),
        .i_a     (w_ua),
        .i_b     (w_ub),
        .o_st    (w_ust),
        .o_res   (w_ures)
    );

    // Thin-line verdict
    assign w_along_w   = WIDE_W'(r_along);
    assign w_big_n     = 32'(r_cnt) > 32'({r_len, 4'd0});
    assign w_steep     = 16'(w_sm) > 16'(r_max_incl);
    assign w_long      = r_len > LEN_W'(64);
    assign w_ratio_bad = (w_along_w <<< 8) < r_rprod;
    assign w_fat       = 64'(r_prod) < (64'(r_cnt) << 2);
    assign w_thin      = (64'(r_cnt) * 10) < 64'(r_len);
    assign w_line      = !w_big_n && !w_steep && (w_long ? !w_ratio_bad : !w_fat) && !w_thin;

    // Sequencer and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rstep     <= '0;
            r_step      <= ST_A0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_x2        <= '0;
            r_ysum      <= '0;
            r_yy        <= '0;
            r_xy2       <= '0;
            r_xx6       <= '0;
            r_min_left  <= LEFT_RST;
            r_max_right <= '0;
            r_have_run  <= 1'b0;
        end else begin
            // drop the output beat once taken
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_xs   <= w_lo;
                        r_xe   <= w_hi;
                        r_y    <= i_row;
                        r_d    <= w_d;
                        r_sp   <= w_sp;
                        r_last <= i_last_run;
                        r_cnt  <= r_cnt + CNT_W'(w_d);
                        if (!r_have_run || w_lo < r_min_left) r_min_left <= w_lo;
                        if (w_hi > r_max_right) r_max_right <= w_hi;
                        r_have_run <= 1'b1;
                        r_rstep    <= '0;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    // consume the product of the previous step
                    case (r_rstep)
                        3'd1: r_sq <= MS_W'(r_prod);
                        3'd2: begin
                            r_p1 <= MS_W'(r_prod);
                            r_x2 <= r_x2 + X2_W'(r_prod);
                        end
                        3'd3: begin
                            r_p2   <= MS_W'(r_prod);
                            r_ysum <= r_ysum + Y_W'(r_prod);
                        end
                        3'd4: r_q <= ((r_sq - MS_W'(r_prod)) << 1) + MS_W'(r_d) - MS_W'(1);
                        3'd5: r_xy2 <= r_xy2 + XY2_W'(r_prod);
                        3'd6: r_yy  <= r_yy + YY_W'(r_prod);
                        3'd7: r_xx6 <= r_xx6 + XX6_W'(r_prod);
                        default: ;
                    endcase
                    r_rstep <= r_rstep + 3'd1;
                    if (r_rstep == 3'd7) begin
                        r_len <= LEN_W'({1'b0, r_max_right} - {1'b0, r_min_left}) + LEN_W'(1);
                        r_step <= ST_A0;
                        if (!r_last) begin
                            r_state <= S_IDLE;
                        end else if ((r_cnt == '0)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_LAUNCH;
                        end
                    end
                end
                S_LAUNCH: r_state <= S_WAIT;
                S_WAIT: begin
                    if (w_ust.done) begin
                        r_state <= S_LAUNCH;
                        r_step  <= t_step'(r_step + 4'd1);
                        unique case (r_step)
                            ST_A0:  r_t0  <= w_ures;
                            ST_A1:  r_a12 <= r_t0 - w_ures;
                            ST_B0:  r_t0  <= w_ures;
                            ST_B1:  r_b12 <= r_t0 - w_ures;
                            ST_C0:  r_t0  <= w_ures;
                            ST_C1:  r_c12 <= r_t0 - w_ures;
                            ST_LIM: begin
                                r_lim <= w_ures;
                                r_dd  <= r_c12 - r_a12;
                            end
                            ST_CX: begin
                                r_cx     <= f_sat_ctr(w_ures);
                                r_dd_abs <= r_dd[WIDE_W-1] ? -r_dd : r_dd;
                            end
                            ST_CY: begin
                                r_cy    <= f_sat_ctr(w_ures);
                                r_degen <= (r_dd == '0) || ((r_dd_abs <<< 4) < r_lim);
                            end
                            ST_AVW: begin
                                r_avw <= f_sat_avw(w_ures);
                                if (r_degen) begin
                                    // near-zero difference: fixed slope, unit moments
                                    r_slope  <= r_deg_slope;
                                    r_across <= MOM_ONE;
                                    r_along  <= MOM_ONE;
                                    r_step   <= ST_RATIO;
                                end
                            end
                            ST_SLOPE:  r_slope  <= f_sat_slp(w_ures);
                            ST_DS2:    r_ds2    <= w_ures;
                            ST_BS:     r_bs     <= r_slope[SLP_W-1] ? -w_ures : w_ures;
                            ST_ACROSS: r_across <= f_sat_mom(w_ures);
                            ST_ALONG:  r_along  <= f_sat_mom(w_ures);
                            ST_RATIO: begin
                                r_rprod <= w_ures;
                                r_state <= S_EMIT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free, then load and clear the blob
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_left    <= r_min_left;
                        r_o_right   <= r_max_right;
                        r_o_cnt     <= r_cnt;
                        if (r_cnt == '0) begin
                            r_o_line   <= 1'b0;
                            r_o_cx     <= '0;
                            r_o_cy     <= '0;
                            r_o_slope  <= '0;
                            r_o_across <= '0;
                            r_o_along  <= '0;
                            r_o_avw    <= '0;
                        end else begin
                            r_o_line   <= w_line;
                            r_o_cx     <= r_cx;
                            r_o_cy     <= r_cy;
                            r_o_slope  <= r_slope;
                            r_o_across <= r_across;
                            r_o_along  <= r_along;
                            r_o_avw    <= r_avw;
                        end
                        r_cnt       <= '0;
                        r_x2        <= '0;
                        r_ysum      <= '0;
                        r_yy        <= '0;
                        r_xy2       <= '0;
                        r_xx6       <= '0;
                        r_min_left  <= LEFT_RST;
                        r_max_right <= '0;
                        r_have_run  <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_is_line       = r_o_line;
    assign o_center_x      = r_o_cx;
    assign o_center_y      = r_o_cy;
    assign o_slope         = r_o_slope;
    assign o_across_moment = r_o_across;
    assign o_along_moment  = r_o_along;
    assign o_average_width = r_o_avw;
    assign o_left_edge     = r_o_left;
    assign o_right_edge    = r_o_right;
    assign o_pixel_count   = r_o_cnt;

    `RMLC_ASSERT_IMP(a_launch_unit_free, i_clk, i_rst_n, r_state == S_LAUNCH, !w_ust.busy)
    `RMLC_ASSERT_IMP(a_done_in_wait, i_clk, i_rst_n, w_ust.done, r_state == S_WAIT)
    `RMLC_ASSERT_NXT(a_emit_holds, i_clk, i_rst_n, r_state == S_EMIT && r_out_valid && i_out_stall, r_state == S_EMIT)
    `RMLC_ASSERT_NXT(a_emit_clears, i_clk, i_rst_n, r_state == S_EMIT && w_out_free, r_out_valid && r_cnt == '0 && !r_have_run)

endmodule

// ===== rtl/rmlc_wide_unit.sv =====
// Shared bit-serial wide arithmetic unit: signed multiply and rounded signed divide.
// Depends on rmlc_pkg; used by run_moment_line_classifier for the end-of-blob math.
module rmlc_wide_unit import rmlc_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_wu_ctl                  i_ctl,
    input  logic signed [WIDE_W-1:0] i_a,
    input  logic signed [WIDE_W-1:0] i_b,
    output t_wu_st                   o_st,
    output logic signed [WIDE_W-1:0] o_res
);

    typedef enum logic [4:0] {
        U_IDLE  = 5'b00001,
        U_PREP  = 5'b00010,
        U_ROUND = 5'b00100,
        U_ITER  = 5'b01000,
        U_SIGN  = 5'b10000
    } t_ustate;

    t_ustate                  r_state, n_state;
    t_wu_op                   r_op;
    logic                     r_neg;
    logic                     r_done;
    logic [WIDE_W-1:0]        r_a;
    logic [WIDE_W-1:0]        r_b;
    logic [WIDE_W-1:0]        r_acc;
    logic [WIDE_W:0]          r_rem;
    logic [IT_W-1:0]          r_cnt;
    logic signed [WIDE_W-1:0] r_res;

    logic [WIDE_W:0]          w_rem2;
    logic                     w_ge;
    logic [WIDE_W-1:0]        w_val;

    // One restoring quotient step: r_a holds the dividend, quotient shifts in at the bottom
    assign w_rem2 = {r_rem[WIDE_W-1:0], r_a[WIDE_W-1]};
    assign w_ge   = (w_rem2 >= {1'b0, r_b});
    assign w_val  = (r_op == WU_MUL) ? r_acc : r_a;

    // Sequence prep, rounding offset, iterations and final sign
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE:  if (i_ctl.start) n_state = U_PREP;
            U_PREP:  n_state = (r_op == WU_DIV) ? U_ROUND : U_ITER;
            U_ROUND: n_state = U_ITER;
            U_ITER: begin
                if (r_op == WU_MUL) begin
                    if (r_b == '0) n_state = U_SIGN;
                end else if (r_cnt == IT_W'(WIDE_W - 1)) begin
                    n_state = U_SIGN;
                end
            end
            U_SIGN:  n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == U_SIGN);
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                if (i_ctl.start) begin
                    r_op <= i_ctl.op;
                    r_a  <= i_a;
                    r_b  <= i_b;
                end
            end
            U_PREP: begin
                // take magnitudes; a multiply keeps its unsigned multiplier
                r_a   <= r_a[WIDE_W-1] ? -r_a : r_a;
                r_acc <= '0;
                if (r_op == WU_DIV) begin
                    r_b   <= r_b[WIDE_W-1] ? -r_b : r_b;
                    r_neg <= r_a[WIDE_W-1] ^ r_b[WIDE_W-1];
                end else begin
                    r_neg <= r_a[WIDE_W-1];
                end
            end
            U_ROUND: begin
                // round half away from zero: (2|n| + |d|) / (2|d|)
                r_a   <= (r_a << 1) + r_b;
                r_b   <= r_b << 1;
                r_rem <= '0;
                r_cnt <= '0;
            end
            U_ITER: begin
                if (r_op == WU_MUL) begin
                    if (r_b[0]) r_acc <= r_acc + r_a;
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end else begin
                    r_rem <= w_ge ? (w_rem2 - {1'b0, r_b}) : w_rem2;
                    r_a   <= {r_a[WIDE_W-2:0], w_ge};
                    r_cnt <= r_cnt + IT_W'(1);
                end
            end
            U_SIGN: begin
                r_res <= r_neg ? -$signed(w_val) : $signed(w_val);
            end
            default: ;
        endcase
    end

    assign o_st.busy = (r_state != U_IDLE);
    assign o_st.done = r_done;
    assign o_res     = r_res;

endmodule
